// ===== src/elevation_grid_binning_assert.svh =====
// ---------------------------------------------------------------------------
// elevation_grid_binning_assert - assertion macros
// Shorthand for clocked checks; expects clk and rst_n in the including scope.
// ---------------------------------------------------------------------------
`ifndef ELEVATION_GRID_BINNING_ASSERT_SVH
`define ELEVATION_GRID_BINNING_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define EGB_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elevation_grid_binning: same-cycle check failed");

// Next-cycle implication, off while in reset.
`define EGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elevation_grid_binning: next-cycle check failed");

`endif

// ===== src/egb_pkg.sv =====
// ---------------------------------------------------------------------------
// egb_pkg - elevation grid binning package
// Grid geometry, memory word layout, codes, states and beat types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package egb_pkg;

    // Grid geometry
    localparam int GRID_SIDE  = 256;
    localparam int COUNT_BITS = 16;
    localparam int Z_W        = 32;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CW         = $clog2(GRID_SIDE);
    localparam int CENTER     = (GRID_SIDE - 1) / 2;
    // signed coordinate width: holds an 8-bit offset plus the center
    localparam int COORD_W    = ((CW + 2) > 9) ? (CW + 2) : 9;

    // Memory word: {sum, count}
    localparam int SUM_W      = Z_W + COUNT_BITS;
    localparam int WORD_W     = SUM_W + COUNT_BITS;

    // Neighbor totals and divider
    localparam int NB_SUM_W   = SUM_W + 2;
    localparam int DEN_W      = COUNT_BITS + 2;
    localparam int DIV_W      = NB_SUM_W;
    localparam int DCNT_W     = $clog2(DIV_W + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic signed [Z_W-1:0] FLOOR_INIT = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic [ADDR_W-1:0]     LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]     ROW_STEP   = ADDR_W'(GRID_SIDE);

    // Opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Elevation source codes
    localparam logic [1:0] SRC_OWN      = 2'd0;
    localparam logic [1:0] SRC_NEIGHBOR = 2'd1;
    localparam logic [1:0] SRC_FLOOR    = 2'd2;
    localparam logic [1:0] SRC_NONE     = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_RD_OWN,
        S_NB,
        S_NB_CHK,
        S_DIV,
        S_DONE
    } egb_state_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic signed [7:0]     x_offset;
        logic signed [7:0]     y_offset;
        logic signed [Z_W-1:0] z_value;
    } egb_in_t;

    typedef struct packed {
        logic signed [Z_W-1:0] elevation;
        logic [1:0]            source;
        logic                  range_error;
    } egb_out_t;

endpackage

`default_nettype wire

// ===== src/egb_ram.sv =====
// ---------------------------------------------------------------------------
// egb_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/elevation_grid_binning.sv =====
// ---------------------------------------------------------------------------
// elevation_grid_binning - lidar point elevation grid, one item at a time
// Add: read at accept, then write-back, then result; clear: a sweep of all memory.
// Read: a populated cell or an empty interior cell with populated neighbors goes to the
// 50-step shift-subtract divider, which sets the read time; other empty cells and off-grid
// or unused-opcode beats report without it. The next beat is accepted the cycle after a
// result is registered. Reset starts a clearing pass with no beat accepted and no result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Cell state lives in one RAM word per cell: {sum, count}. Items are handled
// one at a time, so a read-modify-write never overlaps another access:
//   add   : accept issues the read, next cycle writes sum + z, count + 1
//           (a saturated count writes the old word back unchanged).
//   read  : accept issues the read; a populated cell goes to the divider,
//           an empty border cell returns the floor if one is seen, an empty
//           interior cell streams its four neighbors (one per cycle) into a total first.
//   clear : sweeps every word to zero, one per cycle, then reports.
// The floor (lowest z seen) is a register updated at accept time.
// A finished result sits in the output register, so the next beat may be
// accepted while it waits for the consumer.

module elevation_grid_binning
    import egb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  egb_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output egb_out_t result
);

    // -----------------------------------------------------------------------
    // State
    // -----------------------------------------------------------------------
    egb_state_t state_reg, state_next;

    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic                    clr_res_reg, clr_res_next;   // clear came from an item
    logic signed [Z_W-1:0]   floor_level_reg, floor_level_next;
    logic                    floor_seen_reg, floor_seen_next;
    logic [1:0]              nb_k_reg, nb_k_next;
    logic [DCNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                    result_valid_reg, result_valid_next;

    // payload
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    border_reg, border_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic signed [Z_W-1:0]   res_elev_reg, res_elev_next;
    logic [1:0]              res_src_reg, res_src_next;
    logic                    res_rerr_reg, res_rerr_next;
    logic signed [NB_SUM_W-1:0] nb_sum_reg, nb_sum_next;
    logic [DEN_W-1:0]        nb_cnt_reg, nb_cnt_next;
    logic [DIV_W-1:0]        div_quo_reg, div_quo_next;
    logic [DEN_W-1:0]        div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]        div_den_reg, div_den_next;
    logic                    div_neg_reg, div_neg_next;
    egb_out_t                result_data_reg, result_data_next;

    // -----------------------------------------------------------------------
    // Input decode: grid coordinates, range check, cell index
    // -----------------------------------------------------------------------
    logic signed [COORD_W-1:0] cx_s, cy_s;
    logic [CW-1:0]             cx_u, cy_u;
    logic                      in_range;
    logic                      border_in;
    logic [ADDR_W-1:0]         idx_in;
    logic                      accept;

    assign cx_s = COORD_W'(item.x_offset) + COORD_W'(CENTER);
    assign cy_s = COORD_W'(item.y_offset) + COORD_W'(CENTER);
    assign cx_u = cx_s[CW-1:0];
    assign cy_u = cy_s[CW-1:0];

    assign in_range = (cx_s >= 0) && (cx_s < COORD_W'(GRID_SIDE))
                   && (cy_s >= 0) && (cy_s < COORD_W'(GRID_SIDE));

    assign border_in = (cx_u == '0) || (cx_u == CW'(GRID_SIDE - 1))
                    || (cy_u == '0) || (cy_u == CW'(GRID_SIDE - 1));

    // column-major: index = column * side + row
    assign idx_in = ADDR_W'(cx_u) * ROW_STEP + ADDR_W'(cy_u);

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // -----------------------------------------------------------------------
    // Cell memory
    // -----------------------------------------------------------------------
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    egb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic signed [SUM_W-1:0] rd_sum;
    logic [COUNT_BITS-1:0]   rd_cnt;
    logic signed [SUM_W-1:0] sum_inc;
    logic [COUNT_BITS-1:0]   cnt_inc;

    assign rd_sum  = ram_rdata[WORD_W-1:COUNT_BITS];
    assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
    assign sum_inc = rd_sum + SUM_W'(z_reg);
    assign cnt_inc = rd_cnt + COUNT_BITS'(1);

    // Neighbor addresses: right column, next row, left column, previous row.
    // Only used for interior cells, so no wrap.
    logic [1:0]        nb_sel;
    logic [ADDR_W-1:0] nb_addr;

    assign nb_sel = (state_reg == S_NB) ? (nb_k_reg + 2'd1) : 2'd0;

    always_comb
    begin
        case (nb_sel)
            2'd0:    nb_addr = idx_reg + ROW_STEP;
            2'd1:    nb_addr = idx_reg + ADDR_W'(1);
            2'd2:    nb_addr = idx_reg - ROW_STEP;
            default: nb_addr = idx_reg - ADDR_W'(1);
        endcase
    end

    assign ram_raddr = (state_reg == S_IDLE) ? idx_in : nb_addr;

    // -----------------------------------------------------------------------
    // Divider: restoring, one quotient bit per cycle over the magnitude.
    // Means always fit in Z_W bits, so the low quotient bits are the answer.
    // -----------------------------------------------------------------------
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               div_ge;
    logic [DIV_W-1:0]   quo_step;
    logic               div_last;
    logic [Z_W-1:0]     quo_low;

    assign rem_sh   = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign rem_sub  = rem_sh - {1'b0, div_den_reg};
    assign div_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign quo_step = {div_quo_reg[DIV_W-2:0], div_ge};
    assign div_last = (div_cnt_reg == DCNT_W'(DIV_W - 1));
    assign quo_low  = quo_step[Z_W-1:0];

    logic                       div_load;
    logic signed [NB_SUM_W-1:0] load_num;
    logic [DEN_W-1:0]           load_den;

    logic out_free;
    assign out_free = !result_valid_reg || result_ready;

    // -----------------------------------------------------------------------
    // Next state
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_CELL)
                begin
                    state_next = clr_res_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.opcode)
                        OP_ADD:   state_next = in_range ? S_ADD : S_DONE;
                        OP_READ:  state_next = in_range ? S_RD_OWN : S_DONE;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_RD_OWN:
            begin
                if (rd_cnt != '0)
                begin
                    state_next = S_DIV;
                end
                else if (border_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                if (nb_k_reg == 2'd3)
                begin
                    state_next = S_NB_CHK;
                end
            end
            S_NB_CHK:
            begin
                state_next = (nb_cnt_reg != '0) ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Datapath and memory control
    // -----------------------------------------------------------------------
    always_comb
    begin
        clr_addr_next     = clr_addr_reg;
        clr_res_next      = clr_res_reg;
        floor_level_next  = floor_level_reg;
        floor_seen_next   = floor_seen_reg;
        nb_k_next         = nb_k_reg;
        div_cnt_next      = div_cnt_reg;
        idx_next          = idx_reg;
        border_next       = border_reg;
        z_next            = z_reg;
        res_elev_next     = res_elev_reg;
        res_src_next      = res_src_reg;
        res_rerr_next     = res_rerr_reg;
        nb_sum_next       = nb_sum_reg;
        nb_cnt_next       = nb_cnt_reg;
        div_quo_next      = div_quo_reg;
        div_rem_next      = div_rem_reg;
        div_den_next      = div_den_reg;
        div_neg_next      = div_neg_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_data_next  = result_data_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        ram_wdata         = '0;
        div_load          = 1'b0;
        load_num          = '0;
        load_den          = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_CELL)
                begin
                    clr_res_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = idx_in;
                    border_next   = border_in;
                    z_next        = item.z_value;
                    res_elev_next = '0;
                    res_src_next  = SRC_OWN;
                    res_rerr_next = 1'b0;
                    case (item.opcode)
                        OP_ADD:
                        begin
                            if (!in_range)
                            begin
                                res_rerr_next = 1'b1;
                            end
                            else
                            begin
                                // floor tracks every in-grid point, even into a full cell
                                if (!floor_seen_reg || (item.z_value < floor_level_reg))
                                begin
                                    floor_level_next = item.z_value;
                                end
                                floor_seen_next = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (!in_range)
                            begin
                                res_rerr_next = 1'b1;
                                res_src_next  = SRC_NONE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_addr_next    = '0;
                            clr_res_next     = 1'b1;
                            floor_level_next = FLOOR_INIT;
                            floor_seen_next  = 1'b0;
                        end
                        default:
                        begin
                            res_src_next = SRC_OWN;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                // saturated count: write the word back untouched
                ram_wdata = (rd_cnt == COUNT_MAX) ? ram_rdata : {sum_inc, cnt_inc};
            end
            S_RD_OWN:
            begin
                if (rd_cnt != '0)
                begin
                    div_load     = 1'b1;
                    load_num     = NB_SUM_W'(rd_sum);
                    load_den     = DEN_W'(rd_cnt);
                    res_src_next = SRC_OWN;
                end
                else if (border_reg)
                begin
                    if (floor_seen_reg)
                    begin
                        res_elev_next = floor_level_reg;
                        res_src_next  = SRC_FLOOR;
                    end
                    else
                    begin
                        res_elev_next = '0;
                        res_src_next  = SRC_NONE;
                    end
                end
                else
                begin
                    nb_sum_next = '0;
                    nb_cnt_next = '0;
                    nb_k_next   = 2'd0;
                end
            end
            S_NB:
            begin
                nb_sum_next = nb_sum_reg + NB_SUM_W'(rd_sum);
                nb_cnt_next = nb_cnt_reg + DEN_W'(rd_cnt);
                nb_k_next   = nb_k_reg + 2'd1;
            end
            S_NB_CHK:
            begin
                if (nb_cnt_reg != '0)
                begin
                    div_load     = 1'b1;
                    load_num     = nb_sum_reg;
                    load_den     = nb_cnt_reg;
                    res_src_next = SRC_NEIGHBOR;
                end
                else
                begin
                    res_elev_next = '0;
                    res_src_next  = SRC_NONE;
                end
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                div_quo_next = quo_step;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    res_elev_next = div_neg_reg ? (Z_W'(0) - quo_low) : quo_low;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next            = 1'b1;
                    result_data_next.elevation   = res_elev_reg;
                    result_data_next.source      = res_src_reg;
                    result_data_next.range_error = res_rerr_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        // divider load: work on the magnitude, restore the sign at the end
        if (div_load)
        begin
            div_neg_next = load_num[NB_SUM_W-1];
            div_quo_next = load_num[NB_SUM_W-1] ? DIV_W'(-load_num) : DIV_W'(load_num);
            div_rem_next = '0;
            div_den_next = load_den;
            div_cnt_next = '0;
        end
    end

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            clr_res_reg      <= 1'b0;
            floor_level_reg  <= FLOOR_INIT;
            floor_seen_reg   <= 1'b0;
            nb_k_reg         <= 2'd0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            clr_res_reg      <= clr_res_next;
            floor_level_reg  <= floor_level_next;
            floor_seen_reg   <= floor_seen_next;
            nb_k_reg         <= nb_k_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        border_reg      <= border_next;
        z_reg           <= z_next;
        res_elev_reg    <= res_elev_next;
        res_src_reg     <= res_src_next;
        res_rerr_reg    <= res_rerr_next;
        nb_sum_reg      <= nb_sum_next;
        nb_cnt_reg      <= nb_cnt_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        div_den_reg     <= div_den_next;
        div_neg_reg     <= div_neg_next;
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_data_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
`include "elevation_grid_binning_assert.svh"

    // memory is written only by the add write-back and the clearing sweep
    `EGB_ASSERT_HOLDS(a_ram_write_src, ram_we, (state_reg == S_ADD) || (state_reg == S_CLEAR))
    // an in-grid add goes straight to its write-back cycle
    `EGB_ASSERT_NEXT(a_add_rmw, accept && (item.opcode == OP_ADD) && in_range, state_reg == S_ADD)
    // the divider never runs on a zero count
    `EGB_ASSERT_HOLDS(a_div_nonzero, state_reg == S_DIV, div_den_reg != '0)
    // out-of-grid beats report no elevation
    `EGB_ASSERT_HOLDS(a_rerr_zero, result_valid && result.range_error, result.elevation == '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_elevation_grid_binning.sv =====
// ---------------------------------------------------------------------------
// tb_elevation_grid_binning - self-checking testbench for the elevation grid
// Sends add, read, clear and unused-opcode beats with random gaps and random
// result back-pressure. Each accepted beat is run through a sparse software
// copy of the grid, and each result beat is compared field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elevation_grid_binning;
    import egb_pkg::*;

    localparam int     CLK_HALF      = 5;
    // Slowest legal run: the reset sweep, three clear sweeps and about 400
    // beats, all under worst-case back-pressure. The limit below is several
    // times the length of that run.
    localparam longint CYCLE_LIMIT   = 1_500_000;
    localparam int     SETTLE_CYCLES = 80;     // longer than the slowest read
    localparam int     RANDOM_ITEMS  = 360;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // unused opcode: no state change, all-zero result

    // ------------------------------------------------------------------
    // DUT connections. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    egb_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    egb_out_t result;

    elevation_grid_binning u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow grid. Only touched cells are stored; a missing key is an
    // empty cell (sum 0, count 0), which is exactly the cleared state.
    // ------------------------------------------------------------------
    longint                grid_total [int];
    longint                grid_points [int];
    logic signed [Z_W-1:0] floor_z     = FLOOR_INIT;
    bit                    floor_valid = 1'b0;

    egb_out_t expected_beats [$];

    // Bookkeeping for the summary and the verdict
    int     mismatch_count = 0;
    int     beats_checked  = 0;
    int     ops_sent [4]   = '{default: 0};
    int     read_src [4]   = '{default: 0};
    longint cycle_count    = 0;

    // Sender pacing: bursts of back-to-back beats, then a random gap.
    int burst_left    = 0;

    // Receiver pacing: its own schedule of modes, each held for a while.
    int stall_left = 0;
    int stall_mode = 0;

    function automatic longint total_at(int idx);
        return grid_total.exists(idx) ? grid_total[idx] : 64'sd0;
    endfunction

    function automatic longint points_at(int idx);
        return grid_points.exists(idx) ? grid_points[idx] : 64'sd0;
    endfunction

    function automatic egb_in_t make_item(logic [1:0] op, int x, int y, logic [Z_W-1:0] z);
        egb_in_t it;
        it.opcode   = op;
        it.x_offset = x[7:0];
        it.y_offset = y[7:0];
        it.z_value  = z;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Grid predictor: applies one accepted beat to the shadow grid and
    // returns the result beat the block must produce for it.
    // ------------------------------------------------------------------
    function automatic egb_out_t predict_elevation(egb_in_t it);
        egb_out_t              r;
        int                    cx;
        int                    cy;
        int                    idx;
        bit                    on_grid;
        longint                tot;
        longint                pts;
        logic signed [Z_W-1:0] z;

        r       = '0;
        cx      = int'($signed(it.x_offset)) + CENTER;
        cy      = int'($signed(it.y_offset)) + CENTER;
        on_grid = (cx >= 0) && (cx < GRID_SIDE) && (cy >= 0) && (cy < GRID_SIDE);
        idx     = on_grid ? cx * GRID_SIDE + cy : 0;
        z       = it.z_value;

        case (it.opcode)
            OP_ADD:
            begin
                if (!on_grid)
                    r.range_error = 1'b1;
                else
                begin
                    // a full counter drops the point from the cell only
                    pts = points_at(idx);
                    if (pts < longint'(COUNT_MAX))
                    begin
                        grid_points[idx] = pts + 1;
                        grid_total[idx]  = total_at(idx) + longint'(z);
                    end
                    if (!floor_valid || z < floor_z)
                        floor_z = z;
                    floor_valid = 1'b1;
                end
            end
            OP_READ:
            begin
                if (!on_grid)
                begin
                    r.range_error = 1'b1;
                    r.source      = SRC_NONE;
                end
                else if (points_at(idx) != 0)
                begin
                    tot         = total_at(idx);
                    pts         = points_at(idx);
                    r.elevation = Z_W'(tot / pts);   // SV division truncates toward zero
                    r.source    = SRC_OWN;
                end
                else if (cx == 0 || cx == GRID_SIDE - 1 || cy == 0 || cy == GRID_SIDE - 1)
                begin
                    if (floor_valid)
                    begin
                        r.elevation = floor_z;
                        r.source    = SRC_FLOOR;
                    end
                    else
                        r.source = SRC_NONE;
                end
                else
                begin
                    // empty interior cell: pool the raw points of its 4 neighbors
                    tot = total_at(idx + GRID_SIDE) + total_at(idx + 1)
                        + total_at(idx - GRID_SIDE) + total_at(idx - 1);
                    pts = points_at(idx + GRID_SIDE) + points_at(idx + 1)
                        + points_at(idx - GRID_SIDE) + points_at(idx - 1);
                    if (pts != 0)
                    begin
                        r.elevation = Z_W'(tot / pts);
                        r.source    = SRC_NEIGHBOR;
                    end
                    else
                        r.source = SRC_NONE;
                end
                read_src[r.source]++;
            end
            OP_CLEAR:
            begin
                grid_total.delete();
                grid_points.delete();
                floor_z     = FLOOR_INIT;
                floor_valid = 1'b0;
            end
            default: ;   // unused opcode: no state change, all-zero result
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Send one beat. Valid goes high with the payload and stays high until
    // the handshake; handshake signals are sampled just after the edge, so
    // the values seen are the ones the block saw at that edge.
    // ------------------------------------------------------------------
    task automatic send_item(input egb_in_t it);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_beats = {expected_beats, predict_elevation(it)};
        ops_sent[it.opcode]++;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: ready pattern switches between modes at random
    // (always ready, coin flip, long stalls with rare pulses, mostly ready).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 1) == 1);
            2:       result_ready <= ((stall_left % 8) == 0);
            default: result_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest
    // expectation. Printing is capped; counting is not.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        egb_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                if (mismatch_count < 30)
                    $display("%0t: result beat with nothing expected: elevation %0d source %0d range_error %0b",
                             $time, result.elevation, result.source, result.range_error);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result.elevation !== want.elevation)
                begin
                    if (mismatch_count < 30)
                        $display("%0t: elevation mismatch: expected %0d, actual %0d",
                                 $time, want.elevation, result.elevation);
                    mismatch_count++;
                end
                if (result.source !== want.source)
                begin
                    if (mismatch_count < 30)
                        $display("%0t: source mismatch: expected %0d, actual %0d",
                                 $time, want.source, result.source);
                    mismatch_count++;
                end
                if (result.range_error !== want.range_error)
                begin
                    if (mismatch_count < 30)
                        $display("%0t: range_error mismatch: expected %0b, actual %0b",
                                 $time, want.range_error, result.range_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_beats.size());
            $display("** elevation_grid_binning: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed corners: empty grid, off-grid coordinates, unused opcode,
    // full-scale z with truncating means, neighbor pooling next to the
    // never-reachable last column, floor on border cells, and clear.
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_item(make_item(OP_READ, -127, 5, 0));            // border, no floor yet
        send_item(make_item(OP_READ, 0, 0, 0));               // interior, empty neighbors
        send_item(make_item(OP_READ, -128, 3, 0));            // column off grid
        send_item(make_item(OP_ADD, 7, -128, 99));            // row off grid, dropped
        send_item(make_item(OP_ADD, -128, -128, 32'h8000_0000)); // dropped, floor untouched
        send_item(make_item(OP_UNUSED, 85, -86, 32'hA5A5_5A5A));
        send_item(make_item(OP_ADD, 0, 0, 32'h7FFF_FFFF));
        send_item(make_item(OP_ADD, 0, 0, 32'h8000_0000));    // sum -1 over 2 -> 0
        send_item(make_item(OP_READ, 0, 0, 0));
        send_item(make_item(OP_ADD, 2, 0, -3));
        send_item(make_item(OP_ADD, 2, 2, -4));
        send_item(make_item(OP_READ, 2, 1, 0));               // -7/2 truncates to -3
        send_item(make_item(OP_ADD, 127, 127, 25600));        // highest reachable cell
        send_item(make_item(OP_READ, 127, 127, 0));
        send_item(make_item(OP_READ, 126, 127, 0));
        send_item(make_item(OP_READ, 127, 126, 0));           // one neighbor in last column
        send_item(make_item(OP_READ, -127, 40, 0));           // empty border -> floor
        send_item(make_item(OP_READ, 40, -127, 0));
        send_item(make_item(OP_ADD, -127, -127, 1234));       // corner cell
        send_item(make_item(OP_READ, -127, -127, 0));
        send_item(make_item(OP_CLEAR, 0, 0, 0));
        send_item(make_item(OP_READ, -127, 40, 0));           // floor forgotten
        send_item(make_item(OP_READ, 2, 1, 0));
        send_item(make_item(OP_READ, 127, -128, 0));          // row off grid
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Random mix. Most coordinates land in a small patch near the center so
    // reads find populated cells and empty cells with populated neighbors;
    // the rest hit border lines, the far corner, the whole range and the
    // off-grid value. Two clears split the run, and once midway the sender
    // stops until the pipeline is empty.
    // ------------------------------------------------------------------
    task automatic test_random_mix();
        int         done;
        int         x;
        int         y;
        int         t;
        int         roll;
        logic [1:0] op;
        logic [31:0] z;

        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (done == RANDOM_ITEMS / 3 || done == 2 * RANDOM_ITEMS / 3)
            begin
                send_item(make_item(OP_CLEAR, int'($urandom_range(0, 255)),
                                    int'($urandom_range(0, 255)), $urandom));
                done++;
                continue;
            end
            if (done == RANDOM_ITEMS / 2)
                wait_for_results();

            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                x = int'($urandom_range(0, 8)) - 4;
                y = int'($urandom_range(0, 8)) - 4;
            end
            else if (roll < 70)
            begin
                x = -127;
                y = int'($urandom_range(0, 8)) - 4;
            end
            else if (roll < 80)
            begin
                x = int'($urandom_range(123, 127));
                y = int'($urandom_range(123, 127));
            end
            else if (roll < 95)
            begin
                x = int'($urandom_range(0, 255)) - 128;
                y = int'($urandom_range(0, 255)) - 128;
            end
            else
            begin
                x = -128;
                y = int'($urandom_range(0, 255)) - 128;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                t = x;
                x = y;
                y = t;
            end

            roll = $urandom_range(0, 99);
            op   = (roll < 48) ? OP_ADD : (roll < 95) ? OP_READ : OP_UNUSED;
            z    = ($urandom_range(0, 9) < 7) ? 32'(int'($urandom_range(0, 8000)) - 4000)
                                              : $urandom;
            send_item(make_item(op, x, y, z));
            if (op != OP_UNUSED)
                done++;
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence. The block runs a clearing sweep after reset; the first
    // send simply waits for item_ready.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d adds, %0d reads, %0d clears and %0d unused-opcode beats,",
                 ops_sent[OP_ADD], ops_sent[OP_READ], ops_sent[OP_CLEAR], ops_sent[OP_UNUSED]);
        $display("reads by source own/neighbor/floor/none %0d/%0d/%0d/%0d; %0d results checked.",
                 read_src[SRC_OWN], read_src[SRC_NEIGHBOR], read_src[SRC_FLOOR],
                 read_src[SRC_NONE], beats_checked);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("** elevation_grid_binning: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, expected_beats.size());
            $display("** elevation_grid_binning: FAILED **");
        end
        $finish;
    end

endmodule
